// File: rtl/sha1mh_pkg.sv
package sha1mh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_cmd;

    localparam logic [0:4][31:0] H_INIT = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int         NUM_WORDS   = 5;
    localparam logic [2:0] LAST_INDEX  = 3'd4;
    localparam logic [6:0] LAST_ROUND  = 7'd79;

endpackage

// File: rtl/sha1mh_front.sv
module sha1mh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_has_byte,
    input  logic              i_end_of_message,
    output logic              o_push,
    output sha1mh_pkg::t_cmd  o_push_cmd,
    input  logic              i_queue_full
);
    import sha1mh_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    logic in_acc;

    assign o_in_stall = r_valid & i_queue_full;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_queue_full;
    assign o_push_cmd = r_cmd;

    // Items that carry neither a byte nor an end mark are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_acc) begin
            r_valid <= i_has_byte | i_end_of_message;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd.data_byte      <= i_data_byte;
            r_cmd.has_byte       <= i_has_byte;
            r_cmd.end_of_message <= i_end_of_message;
        end
    end

endmodule

// File: rtl/sha1mh_queue.sv
module sha1mh_queue #(
    parameter int P_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sha1mh_pkg::t_cmd  i_push_cmd,
    output logic              o_full,
    output logic              o_not_empty,
    input  logic              i_pop,
    output sha1mh_pkg::t_cmd  o_pop_cmd
);
    import sha1mh_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd          r_mem [P_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full      = (r_count == CW'(P_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push & ~o_full;
    assign do_pop      = i_pop & o_not_empty;
    assign o_pop_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: rtl/sha1mh_core.sv
module sha1mh_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  sha1mh_pkg::t_cmd  i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);
    import sha1mh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_COMP = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_PAD  = 2'd1;
    localparam logic [1:0] A_LEN  = 2'd2;
    localparam logic [1:0] A_OUT  = 2'd3;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_after, n_after;
    logic [60:0] r_cnt, n_cnt;
    logic [31:0] r_chain [NUM_WORDS];
    logic [31:0] n_chain [NUM_WORDS];
    logic [31:0] r_buf [16];
    logic [31:0] n_buf [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_word, n_out_word;
    logic [2:0]  r_out_index, n_out_index;
    logic        r_out_last, n_out_last;

    logic [3:0]  wi;
    logic [1:0]  lane;
    logic [63:0] bit_len;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] w_new;
    logic [31:0] t_val;
    logic        out_free;

    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] ln,
                                             input logic [7:0] b);
        logic [31:0] res;
        res = (ln == 2'd0) ? '0 : word;
        res[{~ln, 3'b000} +: 8] = b;
        return res;
    endfunction

    assign wi       = r_cnt[5:2];
    assign lane     = r_cnt[1:0];
    assign bit_len  = {r_cnt, 3'b000};
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign o_cmd_pop = (r_state == S_IDLE) & i_cmd_valid;

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_0;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_1;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_3;
        end
        w_new = r_buf[13] ^ r_buf[8] ^ r_buf[2] ^ r_buf[0];
        w_new = {w_new[30:0], w_new[31]};
        t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_buf[0];
    end

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_cnt       = r_cnt;
        n_chain     = r_chain;
        n_buf       = r_buf;
        n_a         = r_chain[0];
        n_b         = r_chain[1];
        n_c         = r_chain[2];
        n_d         = r_chain[3];
        n_e         = r_chain[4];
        n_round     = '0;
        n_idx       = r_idx;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_word  = r_out_word;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.has_byte) begin
                        n_buf[wi] = put_byte(r_buf[wi], lane, i_cmd.data_byte);
                        n_cnt     = r_cnt + 61'd1;
                        if (r_cnt[5:0] == 6'd63) begin
                            n_state = S_COMP;
                            n_after = i_cmd.end_of_message ? A_PAD : A_IDLE;
                        end else if (i_cmd.end_of_message) begin
                            n_state = S_PAD;
                        end
                    end else if (i_cmd.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_buf[wi] = put_byte(r_buf[wi], lane, PAD_BYTE);
                for (int i = 0; i < 16; i++) begin
                    if (4'(i) > wi) begin
                        n_buf[i] = '0;
                    end
                end
                if (r_cnt[5:3] != 3'b111) begin
                    n_buf[14] = bit_len[63:32];
                    n_buf[15] = bit_len[31:0];
                    n_after   = A_OUT;
                end else begin
                    n_after   = A_LEN;
                end
                n_state = S_COMP;
            end
            S_LEN: begin
                for (int i = 0; i < 16; i++) begin
                    n_buf[i] = '0;
                end
                n_buf[14] = bit_len[63:32];
                n_buf[15] = bit_len[31:0];
                n_after   = A_OUT;
                n_state   = S_COMP;
            end
            S_COMP: begin
                n_a = t_val;
                n_b = r_a;
                n_c = {r_b[1:0], r_b[31:2]};
                n_d = r_c;
                n_e = r_d;
                for (int i = 0; i < 15; i++) begin
                    n_buf[i] = r_buf[i + 1];
                end
                n_buf[15] = w_new;
                n_round   = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_chain[4] = r_chain[4] + r_e;
                unique case (r_after)
                    A_IDLE: n_state = S_IDLE;
                    A_PAD:  n_state = S_PAD;
                    A_LEN:  n_state = S_LEN;
                    A_OUT:  n_state = S_OUT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_chain[r_idx];
                    n_out_index = r_idx;
                    n_out_last  = (r_idx == LAST_INDEX);
                    if (r_idx == LAST_INDEX) begin
                        for (int i = 0; i < NUM_WORDS; i++) begin
                            n_chain[i] = H_INIT[i];
                        end
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_after = A_IDLE;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= A_IDLE;
            r_cnt       <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_chain[i] <= H_INIT[i];
            end
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_cnt       <= n_cnt;
            r_round     <= n_round;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf       <= n_buf;
        r_a         <= n_a;
        r_b         <= n_b;
        r_c         <= n_c;
        r_d         <= n_d;
        r_e         <= n_e;
        r_out_word  <= n_out_word;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_index;
    assign o_last_word   = r_out_last;

endmodule

// File: rtl/sha1_message_hash_top.sv
// A byte item is written into the block buffer by the hash core; each full 64-byte block then
// runs 80 rounds on the single round unit, followed by the chaining add, and the core takes
// no new item until it is done. An end item adds a padding step and one compression, or two
// when the length needs a second block, then the five digest words are sent in index order.
// Synchronous active-low reset clears the chaining words, byte count, queue and handshakes;
// the block buffer is not cleared.
module sha1_message_hash_top #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1mh_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic queue_full;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd pop_cmd;

    sha1mh_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_push           (push),
        .o_push_cmd       (push_cmd),
        .i_queue_full     (queue_full)
    );

    sha1mh_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_cmd  (push_cmd),
        .o_full      (queue_full),
        .o_not_empty (cmd_valid),
        .i_pop       (cmd_pop),
        .o_pop_cmd   (pop_cmd)
    );

    sha1mh_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (pop_cmd),
        .o_cmd_pop     (cmd_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == LAST_INDEX)))
        else $error("last word flag does not match the word index");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_word) |=>
        (o_out_valid && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest words are not delivered in consecutive order");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=>
        (!o_out_valid || (o_word_index == 3'd0)))
        else $error("a digest run does not start with the first word");

endmodule
